// ===== src/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

   // command codes carried on req_tuser
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DUMP   = 1'b1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // strobes from the sequencer to the node store
   typedef struct packed {
      logic val_we;
      logic link_we;
      logic rd_en;
   } store_ctl_type;

endpackage

`default_nettype wire

// ===== src/ple_store.sv =====
`default_nettype none

module ple_store #(
   parameter int CAPACITY = 64,
   parameter int ELEM_WIDTH = 64,
   localparam int SlotWidth = $clog2(CAPACITY)
) (
   input  wire logic                  clock,
   input  wire ple_pkg::store_ctl_type ctl,
   input  wire logic [SlotWidth-1:0]  rd_addr,
   input  wire logic [SlotWidth-1:0]  val_waddr,
   input  wire logic [ELEM_WIDTH-1:0] val_wdata,
   input  wire logic [SlotWidth-1:0]  link_waddr,
   input  wire logic [SlotWidth-1:0]  link_wdata,
   output logic      [ELEM_WIDTH-1:0] val_rd,
   output logic      [SlotWidth-1:0]  link_rd
);
   import ple_pkg::*;

   logic [ELEM_WIDTH-1:0] values_mem [CAPACITY];
   logic [SlotWidth-1:0]  links_mem  [CAPACITY];
   logic [ELEM_WIDTH-1:0] val_rd_ff;
   logic [SlotWidth-1:0]  link_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.val_we) begin
         values_mem[val_waddr] <= val_wdata;
      end
      if (ctl.rd_en) begin
         val_rd_ff <= values_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.link_we) begin
         links_mem[link_waddr] <= link_wdata;
      end
      if (ctl.rd_en) begin
         link_rd_ff <= links_mem[rd_addr];
      end
   end

   assign val_rd  = val_rd_ff;
   assign link_rd = link_rd_ff;

endmodule

`default_nettype wire

// ===== src/positional_list_engine.sv =====
// positional_list_engine: bounded singly linked list of element words.
// req channel: req_tuser selects insert or dump; req_tdata carries the value
// and the insert position. Items are taken only while the sequencer is idle.
// rsp channel: one result per insert (status and new length, tlast set);
// a dump gives one result per element in list order with tlast on the final
// one, or a single result with element_valid clear when the list is empty.
// An insert at position p walks the list link by link through the link
// memory, then makes two link writes on its single write port; head inserts
// write their node straight away and rejected inserts go straight to the
// result. A dump streams one element per cycle while rsp_tready stays high,
// the node memories having registered reads. The next item is accepted while
// the final result still sits in the output register.
// When rsp_tready is low the output register holds and the dump walk pauses
// without losing its place. Reset empties the list at once; the node memories
// need no clearing since only written entries are ever followed.
`default_nettype none

module positional_list_engine #(
   parameter int CAPACITY = 64,
   parameter int ELEM_WIDTH = 64,
   localparam int CountWidth = $clog2(CAPACITY + 1),
   localparam int SlotWidth = $clog2(CAPACITY),
   localparam int DataWidth = ((ELEM_WIDTH + CountWidth + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [DataWidth-1:0] req_tdata,  // value, position
   input  wire logic                 req_tuser,  // command
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [DataWidth-1:0] rsp_tdata,  // count, element
   output logic      [2:0]           rsp_tuser,  // status, element_valid
   output logic                      rsp_tlast
);
   import ple_pkg::*;

   localparam int PadWidth = DataWidth - ELEM_WIDTH - CountWidth;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_WALK   = 5'b00010,
      S_LINK   = 5'b00100,
      S_FINISH = 5'b01000,
      S_DUMP   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [SlotWidth-1:0]  head_ff, head_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [SlotWidth-1:0]  cur_ff, cur_in;
   logic [CountWidth-1:0] rem_ff, rem_in;
   logic                  append_ff, append_in;
   logic [1:0]            status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            out_status_ff, out_status_in;
   logic [CountWidth-1:0] out_count_ff, out_count_in;
   logic [ELEM_WIDTH-1:0] out_elem_ff, out_elem_in;
   logic                  out_ev_ff, out_ev_in;
   logic                  out_last_ff, out_last_in;

   store_ctl_type         ctl;
   logic [SlotWidth-1:0]  rd_addr;
   logic [SlotWidth-1:0]  link_waddr;
   logic [SlotWidth-1:0]  link_wdata;
   logic [ELEM_WIDTH-1:0] val_rd;
   logic [SlotWidth-1:0]  link_rd;

   logic                  req_accept;
   logic                  out_free;
   logic                  load;
   logic [ELEM_WIDTH-1:0] req_value;
   logic [CountWidth-1:0] req_position;
   logic [SlotWidth-1:0]  slot;

   assign req_value    = req_tdata[ELEM_WIDTH-1:0];
   assign req_position = req_tdata[ELEM_WIDTH +: CountWidth];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   // new nodes take slots in arrival order
   assign slot         = count_ff[SlotWidth-1:0];

   ple_store #(
      .CAPACITY  (CAPACITY),
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_store (
      .clock     (clock),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .val_waddr (slot),
      .val_wdata (req_value),
      .link_waddr(link_waddr),
      .link_wdata(link_wdata),
      .val_rd    (val_rd),
      .link_rd   (link_rd)
   );

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      rem_in     = rem_ff;
      append_in  = append_ff;
      status_in  = status_ff;
      ctl        = '0;
      rd_addr    = link_rd;
      link_waddr = slot;
      link_wdata = link_rd;
      load       = 1'b0;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_elem_in   = out_elem_ff;
      out_ev_in     = out_ev_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = head_ff;
            if (req_accept) begin
               status_in = ST_OK;
               priority if (req_tuser == CMD_DUMP) begin
                  if (count_ff == '0) begin
                     state_in = S_FINISH;
                  end else begin
                     ctl.rd_en = 1'b1;
                     rem_in    = count_ff - CountWidth'(1);
                     state_in  = S_DUMP;
                  end
               end else if (req_position > count_ff) begin
                  status_in = ST_RANGE;
                  state_in  = S_FINISH;
               end else if (count_ff == CountWidth'(CAPACITY)) begin
                  status_in = ST_FULL;
                  state_in  = S_FINISH;
               end else if (req_position == '0) begin
                  ctl.val_we  = 1'b1;
                  ctl.link_we = 1'b1;
                  link_wdata  = head_ff;
                  head_in     = slot;
                  count_in    = count_ff + CountWidth'(1);
                  state_in    = S_FINISH;
               end else begin
                  // walk to the node just before the position
                  ctl.val_we = 1'b1;
                  ctl.rd_en  = 1'b1;
                  cur_in     = head_ff;
                  rem_in     = req_position - CountWidth'(1);
                  append_in  = (req_position == count_ff);
                  state_in   = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (rem_ff == '0) begin
               // link_rd holds the successor of cur_ff
               ctl.link_we = 1'b1;
               link_waddr  = slot;
               link_wdata  = append_ff ? '0 : link_rd;
               state_in    = S_LINK;
            end else begin
               ctl.rd_en = 1'b1;
               cur_in    = link_rd;
               rem_in    = rem_ff - CountWidth'(1);
            end
         end
         S_LINK: begin
            ctl.link_we = 1'b1;
            link_waddr  = cur_ff;
            link_wdata  = slot;
            count_in    = count_ff + CountWidth'(1);
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               load          = 1'b1;
               out_status_in = status_ff;
               out_count_in  = count_ff;
               out_elem_in   = '0;
               out_ev_in     = 1'b0;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DUMP: begin
            // the read data stays put while the output stalls
            if (out_free) begin
               load          = 1'b1;
               out_status_in = ST_OK;
               out_count_in  = count_ff;
               out_elem_in   = val_rd;
               out_ev_in     = 1'b1;
               out_last_in   = (rem_ff == '0);
               if (rem_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.rd_en = 1'b1;
                  rem_in    = rem_ff - CountWidth'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
      append_ff     <= append_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_elem_ff   <= out_elem_in;
      out_ev_ff     <= out_ev_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PadWidth{1'b0}}, out_elem_ff, out_count_ff};
   assign rsp_tuser  = {out_ev_ff, out_status_ff};
   assign rsp_tlast  = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(CAPACITY))
      else $error("element count above capacity");

   a_walk_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (rem_ff < count_ff))
      else $error("insert walk runs past the list");

   a_dump_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (rem_ff < count_ff))
      else $error("dump walk runs past the list");

   a_splice_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> (cur_ff != slot))
      else $error("splice node equals new slot");

   a_element_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ev_ff) |-> (out_status_ff == ST_OK))
      else $error("element item carries an error status");

endmodule

`default_nettype wire
